// ===== sv/swm_pkg.sv =====
// shared types for the sliding window maximum block
// no dependencies
package swm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    step;
    logic    first;
    logic    shift;
    logic    purge;
    sample_t sample;
  } cell_ctrl_t;

endpackage

// ===== sv/swm_cell.sv =====
// one deque cell: holds a candidate value and its age, hands entries to its left neighbor
// depends on swm_pkg
module swm_cell #(
  parameter int WINDOW_MAX = 64,
  parameter int AGE_W      = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic                keep_left,
  input  logic                right_valid,
  input  swm_pkg::sample_t    right_val,
  input  logic [AGE_W-1:0]    right_age,
  input  logic                right_p_valid,
  input  swm_pkg::sample_t    right_p_val,
  input  logic [AGE_W-1:0]    right_p_age,
  output logic                keep,
  output logic                p_valid,
  output swm_pkg::sample_t    p_val,
  output logic [AGE_W-1:0]    p_age,
  output logic                valid_q,
  output swm_pkg::sample_t    val_q,
  output logic [AGE_W-1:0]    age_q
);

  logic             valid_r, valid_nxt;
  swm_pkg::sample_t val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic [AGE_W-1:0] age_inc;

  assign keep    = valid_r && !ctrl.first && (val_r > ctrl.sample);
  assign age_inc = (age_r == AGE_W'(WINDOW_MAX)) ? age_r : age_r + AGE_W'(1);

  always_comb begin
    if (keep) begin
      p_valid = 1'b1;
      p_val   = val_r;
      p_age   = age_inc;
    end else if (keep_left) begin
      p_valid = 1'b1;
      p_val   = ctrl.sample;
      p_age   = AGE_W'(1);
    end else begin
      p_valid = 1'b0;
      p_val   = val_r;
      p_age   = age_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    age_nxt   = age_r;
    if (ctrl.step) begin
      if (ctrl.shift) begin
        valid_nxt = right_p_valid;
        val_nxt   = right_p_val;
        age_nxt   = right_p_age;
      end else begin
        valid_nxt = p_valid;
        val_nxt   = p_val;
        age_nxt   = p_age;
      end
    end else if (ctrl.purge) begin
      valid_nxt = right_valid;
      val_nxt   = right_val;
      age_nxt   = right_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

  assign valid_q = valid_r;
  assign val_q   = val_r;
  assign age_q   = age_r;

endmodule

// ===== sv/sliding_window_maximum_unit.sv =====
// sliding window maximum over a stream of signed 16-bit samples
// depends on swm_pkg and swm_cell
//
// One item is taken per clock while the result side keeps up and no purge is
// pending; its result, if the window has filled, appears in the output register in
// the cycle after acceptance. The deque is a row of WINDOW_MAX cells: each cell
// compares its candidate with the new sample and the row compacts by one cell per
// cycle. After window_size is made smaller, the block drops candidates that fell
// out of the window before it takes the next item.
module sliding_window_maximum_unit #(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample
  input  logic        in_tuser,   // first_sample
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // window_max
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // window_size
);

  localparam int AGE_W = $clog2(WINDOW_MAX + 1);
  localparam int CW    = (AGE_W > swm_pkg::CFG_W) ? AGE_W : swm_pkg::CFG_W;

  logic [swm_pkg::CFG_W-1:0] window_r;
  logic [CW-1:0]             k_eff;
  logic [AGE_W-1:0]          fill_r, fill_nxt;
  logic                      out_valid_r;
  swm_pkg::sample_t          out_data_r;
  logic                      out_last_r;

  logic                      keep_c   [WINDOW_MAX+1];
  logic                      valid_c  [WINDOW_MAX+1];
  swm_pkg::sample_t          val_c    [WINDOW_MAX+1];
  logic [AGE_W-1:0]          age_c    [WINDOW_MAX+1];
  logic                      pvalid_c [WINDOW_MAX+1];
  swm_pkg::sample_t          pval_c   [WINDOW_MAX+1];
  logic [AGE_W-1:0]          page_c   [WINDOW_MAX+1];
  logic                      keep_out [WINDOW_MAX];

  swm_pkg::cell_ctrl_t       ctrl;
  logic                      purge_need;
  logic                      step;
  logic                      emit;

  always_comb begin
    if (window_r == '0) begin
      k_eff = CW'(1);
    end else if (CW'(window_r) > CW'(WINDOW_MAX)) begin
      k_eff = CW'(WINDOW_MAX);
    end else begin
      k_eff = CW'(window_r);
    end
  end

  assign keep_c[0] = 1'b1;
  assign valid_c[WINDOW_MAX]  = 1'b0;
  assign val_c[WINDOW_MAX]    = '0;
  assign age_c[WINDOW_MAX]    = '0;
  assign pvalid_c[WINDOW_MAX] = keep_out[WINDOW_MAX-1];
  assign pval_c[WINDOW_MAX]   = ctrl.sample;
  assign page_c[WINDOW_MAX]   = AGE_W'(1);

  assign purge_need = valid_c[1] && (CW'(age_c[1]) >= k_eff);
  assign in_tready  = !purge_need && (!out_valid_r || out_tready);
  assign step       = in_tvalid && in_tready;

  assign ctrl.step   = step;
  assign ctrl.first  = in_tuser;
  assign ctrl.sample = swm_pkg::sample_t'(in_tdata);
  assign ctrl.shift  = keep_out[0] && (CW'(age_c[0]) >= k_eff);
  assign ctrl.purge  = purge_need;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      swm_cell #(
        .WINDOW_MAX(WINDOW_MAX),
        .AGE_W     (AGE_W)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .keep_left    (keep_c[gi]),
        .right_valid  (valid_c[gi+1]),
        .right_val    (val_c[gi+1]),
        .right_age    (age_c[gi+1]),
        .right_p_valid(pvalid_c[gi+1]),
        .right_p_val  (pval_c[gi+1]),
        .right_p_age  (page_c[gi+1]),
        .keep         (keep_out[gi]),
        .p_valid      (pvalid_c[gi]),
        .p_val        (pval_c[gi]),
        .p_age        (page_c[gi]),
        .valid_q      (valid_c[gi]),
        .val_q        (val_c[gi]),
        .age_q        (age_c[gi])
      );
      if (gi > 0) begin : g_chain
        assign keep_c[gi] = keep_out[gi-1];
      end
    end
  endgenerate

  always_comb begin
    if (in_tuser) begin
      fill_nxt = AGE_W'(1);
    end else if (fill_r < AGE_W'(WINDOW_MAX)) begin
      fill_nxt = fill_r + AGE_W'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  assign emit = CW'(fill_nxt) >= k_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= swm_pkg::WINDOW_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      if (step) begin
        fill_r      <= fill_nxt;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= ctrl.shift ? pval_c[1] : pval_c[0];
      out_last_r <= in_tlast;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
